// ===== hdl/hmac_sha256_mac_assert.svh =====
// Assertion macros used by the port checker.
`ifndef HMAC_SHA256_MAC_ASSERT_SVH
`define HMAC_SHA256_MAC_ASSERT_SVH

// Antecedent implies consequent on the next edge.
`define HS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent on the same edge.
`define HS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/hs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HMAC-SHA256 package
// Round constants, initial hash values, pad constants and controller types.
// ----------------------------------------------------------------------------
package hs_pkg;

  localparam int unsigned NumKeyWords = 8;
  localparam logic [31:0] IpadWord = 32'h36363636;
  localparam logic [31:0] OpadWord = 32'h5c5c5c5c;

  // Datapath block load selections.
  typedef enum logic [2:0] {
    LD_NONE  = 3'd0,
    LD_IPAD  = 3'd1,
    LD_OPAD  = 3'd2,
    LD_TAIL  = 3'd3,
    LD_LEN   = 3'd4,
    LD_LENZ  = 3'd5,
    LD_INNER = 3'd6
  } load_sel_t;

  typedef struct packed {
    logic      init_chain;   // chain := initial hash values
    load_sel_t load;         // whole-block load
    logic      put_byte;     // write one message byte
    logic      start;        // start a 64-round compression
    logic      save_inner;   // latch the inner digest
    logic      clear_count;  // zero byte position and bit count
  } dp_cmd_t;

  typedef struct packed {
    logic       busy;
    logic [5:0] pos;
  } dp_stat_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h;
    unique case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== hdl/hmac_sha256_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HMAC-SHA256 MAC engine
// Streams a message one byte per request and returns the 256-bit MAC.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload
// in_     | slave     | tdata = data_byte[7:0]; tuser = byte_present; tlast = end_of_message
// out_    | master    | tdata = mac_high, mac_upper_mid, mac_lower_mid, mac_low (low first)
// cfg_    | slave     | cfg_index selects key_word_N, cfg_data is its value
// Each request goes through S_BYTE before the next is taken; a byte that fills a block
// adds a compression. The first request of a message first compresses the inner key block.
// The MAC follows the padding block, an extra block when the padding spills, and the outer hash;
// a result not yet taken holds the next MAC in S_DONE, and no request is accepted meanwhile.
// rst_n is synchronous; the key resets to zero.
// ----------------------------------------------------------------------------
module hmac_sha256_mac import hs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tuser,   // byte_present
  input  logic         in_tlast,   // end_of_message
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [255:0] out_tdata,  // mac_high, mac_upper_mid, mac_lower_mid, mac_low
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  logic [63:0]  key_r [NumKeyWords];
  logic [511:0] key_bits;
  dp_cmd_t      cmd;
  dp_stat_t     stat;
  logic [255:0] digest;
  logic         res_load, res_free;
  logic         out_valid_r;
  logic [255:0] out_data_r;
  logic [7:0]   byte_r;

  assign cfg_ready = 1'b1;
  assign res_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumKeyWords; i++) key_r[i] <= '0;
    end else if (cfg_valid) begin
      key_r[cfg_index] <= cfg_data;
    end
  end

  // The byte is registered here and written into the block from S_BYTE, once no compression runs.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) byte_r <= in_tdata;
  end

  always_comb begin
    for (int i = 0; i < NumKeyWords; i++) key_bits[511 - 64*i -: 64] = key_r[i];
  end

  hs_control u_ctl (
    .clk, .rst_n,
    .in_tvalid,
    .in_tready,
    .byte_present(in_tuser),
    .end_of_message(in_tlast),
    .stat, .cmd, .res_load, .res_free
  );

  hs_datapath u_dp (
    .clk, .rst_n, .cmd,
    .byte_in(byte_r),
    .key_bits, .stat, .digest
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_load) begin
      out_data_r[63:0]    <= digest[255:192];
      out_data_r[127:64]  <= digest[191:128];
      out_data_r[191:128] <= digest[127:64];
      out_data_r[255:192] <= digest[63:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

endmodule

// ===== hdl/hs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HMAC-SHA256 datapath
// Message block, schedule window, round unit (one round a cycle) and chain.
// ----------------------------------------------------------------------------
module hs_datapath import hs_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  dp_cmd_t        cmd,
  input  logic [7:0]     byte_in,
  input  logic [511:0]   key_bits,
  output dp_stat_t       stat,
  output logic [255:0]   digest
);

  logic [31:0] blk_r [16];
  logic [31:0] blk_nxt [16];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] chain_r [8];
  logic [31:0] chain_nxt [8];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] inner_r [8];
  logic [5:0]  round_r, round_nxt;
  logic        busy_r, busy_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [63:0] total;
  logic [31:0] s0, s1, w_new, t1, t2, e, a;

  assign total = bits_r + 64'd512;
  assign e = v_r[4];
  assign a = v_r[0];
  assign t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
            + ((e & v_r[5]) ^ (~e & v_r[6])) + round_k(round_r) + w_r[0];
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
            + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign w_new = w_r[0] + s0 + w_r[9] + s1;

  always_comb begin
    blk_nxt = blk_r;
    w_nxt = w_r;
    chain_nxt = chain_r;
    v_nxt = v_r;
    round_nxt = round_r;
    busy_nxt = busy_r;
    pos_nxt = pos_r;
    bits_nxt = bits_r;
    if (cmd.init_chain) begin
      for (int i = 0; i < 8; i++) chain_nxt[i] = init_hash(3'(i));
    end
    unique case (cmd.load)
      LD_IPAD, LD_OPAD: begin
        for (int i = 0; i < 16; i++) begin
          blk_nxt[i] = key_bits[511 - 32*i -: 32] ^
                       ((cmd.load == LD_IPAD) ? IpadWord : OpadWord);
        end
      end
      LD_TAIL, LD_LEN: begin
        // The end marker goes at the fill position and the bytes after it are
        // cleared, up to the length field when it fits in this block.
        for (int i = 0; i < 16; i++) begin
          for (int b = 0; b < 4; b++) begin
            if (cmd.load == LD_TAIL || i < 14) begin
              if (4*i + b == int'(pos_r)) blk_nxt[i][31 - 8*b -: 8] = 8'h80;
              else if (4*i + b > int'(pos_r)) blk_nxt[i][31 - 8*b -: 8] = 8'h00;
            end
          end
        end
        if (cmd.load == LD_LEN) begin
          blk_nxt[14] = total[63:32];
          blk_nxt[15] = total[31:0];
        end
      end
      LD_LENZ: begin
        for (int i = 0; i < 14; i++) blk_nxt[i] = '0;
        blk_nxt[14] = total[63:32];
        blk_nxt[15] = total[31:0];
      end
      LD_INNER: begin
        for (int i = 0; i < 8; i++) blk_nxt[i] = inner_r[i];
        blk_nxt[8] = 32'h80000000;
        for (int i = 9; i < 15; i++) blk_nxt[i] = '0;
        blk_nxt[15] = 32'd768;
      end
      default: ;
    endcase
    if (cmd.put_byte) begin
      for (int b = 0; b < 4; b++) begin
        if (pos_r[1:0] == 2'(b)) blk_nxt[pos_r[5:2]][31 - 8*b -: 8] = byte_in;
      end
      pos_nxt = pos_r + 6'd1;
      bits_nxt = bits_r + 64'd8;
    end
    if (cmd.clear_count) begin
      pos_nxt = '0;
      bits_nxt = '0;
    end
    if (cmd.start) begin
      busy_nxt = 1'b1;
      round_nxt = '0;
      w_nxt = blk_r;
      v_nxt = chain_r;
    end else if (busy_r) begin
      v_nxt[7] = v_r[6]; v_nxt[6] = v_r[5]; v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2]; v_nxt[2] = v_r[1]; v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
      for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
      w_nxt[15] = w_new;
      round_nxt = round_r + 6'd1;
      if (round_r == 6'd63) begin
        busy_nxt = 1'b0;
        for (int i = 0; i < 8; i++) chain_nxt[i] = chain_r[i] + v_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      round_r <= '0;
      pos_r <= '0;
      bits_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      round_r <= round_nxt;
      pos_r <= pos_nxt;
      bits_r <= bits_nxt;
    end
    blk_r <= blk_nxt;
    w_r <= w_nxt;
    chain_r <= chain_nxt;
    v_r <= v_nxt;
    if (cmd.save_inner) inner_r <= chain_r;
  end

  assign stat.busy = busy_r;
  assign stat.pos = pos_r;

  always_comb begin
    for (int i = 0; i < 8; i++) digest[255 - 32*i -: 32] = chain_r[i];
  end

endmodule

// ===== hdl/hs_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HMAC-SHA256 controller
// Sequences the inner pad, message blocks, padding and the outer hash.
// ----------------------------------------------------------------------------
module hs_control import hs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     byte_present,
  input  logic     end_of_message,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     res_load,
  input  logic     res_free
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_KEY    = 13'b0000000000010,
    S_BYTE   = 13'b0000000000100,
    S_BLK    = 13'b0000000001000,
    S_PAD    = 13'b0000000010000,
    S_PADC   = 13'b0000000100000,
    S_LENZ   = 13'b0000001000000,
    S_LENC   = 13'b0000010000000,
    S_OPAD   = 13'b0000100000000,
    S_OSTART = 13'b0001000000000,
    S_INNER  = 13'b0010000000000,
    S_FSTART = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   started_r, started_nxt;
  logic   held_pres_r, held_last_r;
  logic   take;

  // A request is taken only when no compression is running.
  assign in_tready = (state_r == S_IDLE) && !stat.busy;
  assign take = in_tvalid && in_tready && (byte_present || end_of_message);

  always_comb begin
    state_nxt = state_r;
    started_nxt = started_r;
    cmd = '0;
    cmd.load = LD_NONE;
    res_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          if (!started_r) begin
            cmd.init_chain = 1'b1;
            cmd.load = LD_IPAD;
            cmd.clear_count = 1'b1;
            started_nxt = 1'b1;
            state_nxt = S_KEY;
          end else begin
            state_nxt = S_BYTE;
          end
        end
      end
      S_KEY: begin
        cmd.start = 1'b1;
        state_nxt = S_BYTE;
      end
      S_BYTE: begin
        if (!stat.busy) begin
          if (held_pres_r) begin
            cmd.put_byte = 1'b1;
            if (stat.pos == 6'd63) state_nxt = S_BLK;
            else state_nxt = held_last_r ? S_PAD : S_IDLE;
          end else begin
            state_nxt = S_PAD;
          end
        end
      end
      S_BLK: begin
        cmd.start = 1'b1;
        state_nxt = held_last_r ? S_PAD : S_IDLE;
      end
      S_PAD: begin
        if (!stat.busy) begin
          // A marker past byte 55 leaves no room for the length field.
          if (stat.pos >= 6'd56) begin
            cmd.load = LD_TAIL;
            state_nxt = S_PADC;
          end else begin
            cmd.load = LD_LEN;
            state_nxt = S_LENC;
          end
        end
      end
      S_PADC: begin
        cmd.start = 1'b1;
        state_nxt = S_LENZ;
      end
      S_LENZ: begin
        if (!stat.busy) begin
          cmd.load = LD_LENZ;
          state_nxt = S_LENC;
        end
      end
      S_LENC: begin
        cmd.start = 1'b1;
        state_nxt = S_OPAD;
      end
      S_OPAD: begin
        if (!stat.busy) begin
          cmd.save_inner = 1'b1;
          cmd.init_chain = 1'b1;
          cmd.load = LD_OPAD;
          state_nxt = S_OSTART;
        end
      end
      S_OSTART: begin
        cmd.start = 1'b1;
        state_nxt = S_INNER;
      end
      S_INNER: begin
        if (!stat.busy) begin
          cmd.load = LD_INNER;
          state_nxt = S_FSTART;
        end
      end
      S_FSTART: begin
        cmd.start = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!stat.busy && res_free) begin
          res_load = 1'b1;
          cmd.clear_count = 1'b1;
          started_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      started_r <= 1'b0;
      held_pres_r <= 1'b0;
      held_last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      started_r <= started_nxt;
      if (take) begin
        held_pres_r <= byte_present;
        held_last_r <= end_of_message;
      end
    end
  end

endmodule

// ===== hdl/hmac_sha256_mac_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HMAC-SHA256 port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "hmac_sha256_mac_assert.svh"
module hmac_sha256_mac_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         in_tlast,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [255:0] out_tdata
);

  `HS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `HS_ASSERT_NEXT(a_no_mac_early, clk, rst_n, in_tvalid && in_tready && !in_tlast && !out_tvalid, !out_tvalid)
  `HS_ASSERT_NEXT(a_busy_after_last, clk, rst_n, in_tvalid && in_tready && in_tlast, !in_tready)
  `HS_ASSERT_NOW(a_out_valid_known, clk, rst_n, 1'b1, !$isunknown(out_tvalid))

endmodule

bind hmac_sha256_mac hmac_sha256_mac_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .in_tlast, .out_tvalid, .out_tready, .out_tdata
);
